FILE: rtl/cre_pkg.sv
// shared constants, codes and types of the command retry engine
`default_nettype none
package cre_pkg;

	// sizes
	localparam int MAX_CMD_BYTES   = 32;
	localparam int MAX_REPLY_BYTES = 64;
	localparam int STORE_DEPTH     = MAX_CMD_BYTES + 2;
	localparam int ADDR_W          = $clog2(STORE_DEPTH);
	localparam int CMD_CNT_W       = $clog2(STORE_DEPTH + 1);
	localparam int REPLY_CNT_W     = 7;
	localparam int TIMER_W         = 16;
	localparam int LIMIT_W         = 4;
	localparam int CRC_W           = 16;
	localparam int CFG_IDX_W       = 1;
	localparam int CFG_DATA_W      = 16;

	// fixed values
	localparam logic [7:0]       ACK_VALUE = 8'hFF;
	localparam logic [CRC_W-1:0] CRC_POLY  = 16'h1021;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'd1;

	// result kinds
	localparam logic [1:0] KIND_TX    = 2'd0;
	localparam logic [1:0] KIND_REPLY = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;

	typedef enum logic [1:0] {
		REQ_CMD  = 2'd0,
		REQ_LINE = 2'd1,
		REQ_TICK = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_WAIT = 2'd1,
		PH_RECV = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ACT_NONE   = 2'd0,
		ACT_FINISH = 2'd1,
		ACT_RETRY  = 2'd2
	} act_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_CMD_CRC,
		ST_START,
		ST_ADD_HI,
		ST_HI_CRC,
		ST_ADD_LO,
		ST_LO_CRC,
		ST_ARM,
		ST_SEND_INIT,
		ST_SEND_RD,
		ST_SEND_OUT,
		ST_REPLY_CRC,
		ST_REPLY_OUT,
		ST_RETRY,
		ST_FINISH
	} state_t;

	// crc unit request and response
	typedef struct packed {
		logic             start;
		logic [CRC_W-1:0] seed;
		logic [7:0]       data;
	} crc_req_t;

	typedef struct packed {
		logic             done;
		logic [CRC_W-1:0] crc;
	} crc_rsp_t;

	// command store write port
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} st_wr_t;

endpackage
`default_nettype wire

FILE: rtl/cre_crc_serial.sv
// nibble-serial crc-16/xmodem unit, high nibble first, with a registered done pulse
`default_nettype none
module cre_crc_serial
	import cre_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire crc_req_t req,
	output crc_rsp_t      rsp
);

	logic [CRC_W-1:0] crc_q;
	logic [7:0]       dat_q;
	logic             run_q;
	logic             nib_q;
	logic             done_q;

	// four msb-first shift steps of the crc register
	function automatic logic [CRC_W-1:0] step4(input logic [CRC_W-1:0] c,
			input logic [3:0] d);
		logic [CRC_W-1:0] r;
		logic             fb;
		r = c;
		for (int i = 3; i >= 0; i--) begin
			fb = r[CRC_W-1] ^ d[i];
			r  = {r[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
		end
		return r;
	endfunction

	// control: start, high and low nibble steps, done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			nib_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				nib_q <= 1'b0;
			end else if (run_q) begin
				nib_q <= 1'b1;
				if (nib_q) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: crc and byte shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			crc_q <= req.seed;
			dat_q <= req.data;
		end else if (run_q) begin
			crc_q <= step4(crc_q, dat_q[7:4]);
			dat_q <= {dat_q[3:0], 4'h0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.crc  = crc_q;

endmodule
`default_nettype wire

FILE: rtl/cre_cmd_store.sv
// command byte store, one write and one registered read per cycle
`default_nettype none
module cre_cmd_store
	import cre_pkg::*;
(
	input  wire logic              clk,
	input  wire st_wr_t            wr,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]             rd_data
);

	logic [7:0] mem [STORE_DEPTH];
	logic [7:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

FILE: rtl/crc_command_retry_engine.sv
// top level of the crc-16 command engine with reply check and retries
//
// Input items carry a request type: a host command byte, a byte received
// from the line, or a time tick. Command bytes are stored; the one marked
// cmd_last starts a transaction, optionally appending the CRC, and the
// stored command goes out as transmit results. Line bytes are forwarded to
// the host and checked; a timeout, bad ack, overrun or bad CRC resends the
// command until retry_limit attempts, then a done result reports failure.
// One item is handled at a time: in_stall is high from acceptance until all
// of its results are loaded into the output register. A stored command
// byte and each appended CRC byte take a store write and a pass of the
// nibble-serial CRC unit, a line byte takes a CRC pass and then a load of
// the output register, and each transmitted byte takes a store read and
// then a load of the output register.
// A stalled receiver holds the output register and the sequencer waits.
// Reset clears the sequencer and counters and loads retry_limit 3 and
// timeout_ticks 10; the command store is not cleared. Configuration writes
// are taken in any cycle and belong to idle periods.
`default_nettype none
module crc_command_retry_engine
	import cre_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// input items
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [1:0]            req_type,
	input  wire logic [7:0]            data_byte,
	input  wire logic                  cmd_last,
	input  wire logic                  add_crc,
	input  wire logic [6:0]            reply_len,
	input  wire logic                  reply_variable,
	// result items
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [1:0]                 kind,
	output logic [7:0]                 out_byte,
	output logic                       status,
	output logic                       last
);

	localparam logic [CMD_CNT_W-1:0]   CMD_MAX   = CMD_CNT_W'(MAX_CMD_BYTES);
	localparam logic [REPLY_CNT_W-1:0] REPLY_MAX = REPLY_CNT_W'(MAX_REPLY_BYTES);
	localparam logic [REPLY_CNT_W-1:0] REPLY_SAT = '1;
	localparam logic [TIMER_W-1:0]     TIMER_SAT = '1;
	localparam logic [LIMIT_W-1:0]     LIMIT_SAT = '1;

	state_t state_q, state_nxt;

	// configuration registers
	logic [LIMIT_W-1:0] retry_limit_q;
	logic [TIMER_W-1:0] timeout_q;

	// latched item
	req_t       req_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       add_q;
	logic [6:0] len_q;
	logic       var_q;

	// transaction state
	phase_t                 phase_q;
	logic [CMD_CNT_W-1:0]   cmd_count_q;
	logic [CRC_W-1:0]       cmd_crc_q;
	logic [CRC_W-1:0]       crc_hold_q;
	logic [CRC_W-1:0]       reply_crc_q;
	logic [REPLY_CNT_W-1:0] reply_count_q;
	logic [15:0]            recent_q;
	logic [LIMIT_W-1:0]     attempt_q;
	logic [TIMER_W-1:0]     timer_q;
	logic                   exp_var_q;
	logic [6:0]             exp_len_q;
	logic                   end_mark_q;
	act_t                   act_q;
	logic                   fin_status_q;
	logic [CMD_CNT_W-1:0]   idx_q;

	// output register
	logic       out_valid_q;
	logic [1:0] kind_q;
	logic [7:0] out_byte_q;
	logic       status_q;
	logic       last_q_out;

	// submodule links
	crc_req_t   crc_req;
	crc_rsp_t   crc_rsp;
	st_wr_t     st_wr;
	logic [7:0] st_rd_data;

	// derived values
	logic                   in_acc;
	logic                   out_free;
	logic                   out_load;
	logic [TIMER_W-1:0]     timer_inc;
	logic [LIMIT_W-1:0]     attempt_inc;
	logic [REPLY_CNT_W-1:0] reply_cnt_inc;
	logic [CMD_CNT_W-1:0]   idx_nxt;
	logic                   send_last;
	logic [6:0]             len_eff;
	act_t                   act_nxt;

	assign in_acc        = in_valid && !in_stall;
	assign out_free      = !out_valid_q || !out_stall;
	assign timer_inc     = (timer_q != TIMER_SAT) ? timer_q + 1'b1 : timer_q;
	assign attempt_inc   = (attempt_q != LIMIT_SAT) ? attempt_q + 1'b1 : attempt_q;
	assign reply_cnt_inc = (reply_count_q != REPLY_SAT) ? reply_count_q + 1'b1
	                                                    : reply_count_q;
	assign idx_nxt       = idx_q + 1'b1;
	assign send_last     = (idx_nxt == cmd_count_q);

	// reply length clamp
	always_comb begin
		if (len_q == '0) begin
			len_eff = 7'd1;
		end else if (len_q > REPLY_MAX) begin
			len_eff = REPLY_MAX;
		end else begin
			len_eff = len_q;
		end
	end

	// reply verdict from the updated crc and count
	always_comb begin
		act_nxt = ACT_NONE;
		if (exp_var_q) begin
			if (end_mark_q) begin
				act_nxt = (crc_rsp.crc == '0) ? ACT_FINISH : ACT_RETRY;
			end else if (reply_cnt_inc >= REPLY_MAX) begin
				act_nxt = ACT_RETRY;
			end
		end else if (exp_len_q == 7'd1) begin
			act_nxt = (byte_q == ACK_VALUE) ? ACT_FINISH : ACT_RETRY;
		end else if (reply_cnt_inc >= exp_len_q) begin
			act_nxt = (crc_rsp.crc == '0) ? ACT_FINISH : ACT_RETRY;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) state_nxt = ST_DECODE;
			end
			ST_DECODE: begin
				state_nxt = ST_IDLE;
				case (req_q)
					REQ_CMD: begin
						if (phase_q == PH_IDLE) begin
							if (cmd_count_q < CMD_MAX) begin
								state_nxt = ST_CMD_CRC;
							end else if (last_q) begin
								state_nxt = ST_START;
							end
						end
					end
					REQ_LINE: begin
						if (phase_q != PH_IDLE) state_nxt = ST_REPLY_CRC;
					end
					REQ_TICK: begin
						if (phase_q == PH_WAIT && timer_inc >= timeout_q) begin
							state_nxt = ST_RETRY;
						end
					end
					default: state_nxt = ST_IDLE;
				endcase
			end
			ST_CMD_CRC: begin
				if (crc_rsp.done) state_nxt = last_q ? ST_START : ST_IDLE;
			end
			ST_START:     state_nxt = add_q ? ST_ADD_HI : ST_ARM;
			ST_ADD_HI:    state_nxt = ST_HI_CRC;
			ST_HI_CRC: begin
				if (crc_rsp.done) state_nxt = ST_ADD_LO;
			end
			ST_ADD_LO:    state_nxt = ST_LO_CRC;
			ST_LO_CRC: begin
				if (crc_rsp.done) state_nxt = ST_ARM;
			end
			ST_ARM:       state_nxt = (retry_limit_q == '0) ? ST_FINISH : ST_SEND_INIT;
			ST_SEND_INIT: state_nxt = ST_SEND_RD;
			ST_SEND_RD:   state_nxt = ST_SEND_OUT;
			ST_SEND_OUT: begin
				if (out_free) state_nxt = send_last ? ST_IDLE : ST_SEND_RD;
			end
			ST_REPLY_CRC: begin
				if (crc_rsp.done) state_nxt = ST_REPLY_OUT;
			end
			ST_REPLY_OUT: begin
				if (out_free) begin
					case (act_q)
						ACT_FINISH: state_nxt = ST_FINISH;
						ACT_RETRY:  state_nxt = ST_RETRY;
						default:    state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_RETRY: begin
				state_nxt = (attempt_inc >= retry_limit_q) ? ST_FINISH : ST_SEND_INIT;
			end
			ST_FINISH: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// control strobes
	always_comb begin
		in_stall      = (state_q != ST_IDLE);
		crc_req.start = 1'b0;
		crc_req.seed  = cmd_crc_q;
		crc_req.data  = byte_q;
		st_wr.en      = 1'b0;
		st_wr.addr    = cmd_count_q[ADDR_W-1:0];
		st_wr.data    = byte_q;
		out_load      = 1'b0;
		case (state_q)
			ST_DECODE: begin
				if (req_q == REQ_CMD && phase_q == PH_IDLE && cmd_count_q < CMD_MAX) begin
					crc_req.start = 1'b1;
					st_wr.en      = 1'b1;
				end
				if (req_q == REQ_LINE && phase_q != PH_IDLE) begin
					crc_req.start = 1'b1;
					crc_req.seed  = reply_crc_q;
				end
			end
			ST_ADD_HI: begin
				crc_req.start = 1'b1;
				crc_req.data  = crc_hold_q[15:8];
				st_wr.en      = 1'b1;
				st_wr.data    = crc_hold_q[15:8];
			end
			ST_ADD_LO: begin
				crc_req.start = 1'b1;
				crc_req.data  = crc_hold_q[7:0];
				st_wr.en      = 1'b1;
				st_wr.data    = crc_hold_q[7:0];
			end
			ST_SEND_OUT:  out_load = out_free;
			ST_REPLY_OUT: out_load = out_free;
			ST_FINISH:    out_load = out_free;
			default: ;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= LIMIT_W'(3);
			timeout_q     <= TIMER_W'(10);
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_RETRY_LIMIT:   retry_limit_q <= cfg_data[LIMIT_W-1:0];
				CFG_TIMEOUT_TICKS: timeout_q     <= cfg_data[TIMER_W-1:0];
				default: ;
			endcase
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q  <= req_t'(req_type);
			byte_q <= data_byte;
			last_q <= cmd_last;
			add_q  <= add_crc;
			len_q  <= reply_len;
			var_q  <= reply_variable;
		end
	end

	// transaction state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			cmd_count_q   <= '0;
			cmd_crc_q     <= '0;
			crc_hold_q    <= '0;
			reply_crc_q   <= '0;
			reply_count_q <= '0;
			recent_q      <= '0;
			attempt_q     <= '0;
			timer_q       <= '0;
			exp_var_q     <= 1'b0;
			exp_len_q     <= '0;
			end_mark_q    <= 1'b0;
			act_q         <= ACT_NONE;
			fin_status_q  <= 1'b0;
			idx_q         <= '0;
		end else begin
			if (st_wr.en) cmd_count_q <= cmd_count_q + 1'b1;
			case (state_q)
				ST_DECODE: begin
					if (req_q == REQ_LINE) begin
						end_mark_q <= (reply_count_q >= REPLY_CNT_W'(2)) &&
						              (recent_q[15:8] == 8'h00);
					end
					if (req_q == REQ_TICK && phase_q == PH_WAIT) timer_q <= timer_inc;
				end
				ST_CMD_CRC, ST_HI_CRC, ST_LO_CRC: begin
					if (crc_rsp.done) cmd_crc_q <= crc_rsp.crc;
				end
				ST_START: begin
					exp_var_q  <= var_q;
					exp_len_q  <= len_eff;
					crc_hold_q <= cmd_crc_q;
				end
				ST_ARM: begin
					attempt_q    <= '0;
					fin_status_q <= 1'b1;
				end
				ST_SEND_INIT: begin
					phase_q       <= PH_WAIT;
					timer_q       <= '0;
					reply_crc_q   <= cmd_crc_q;
					reply_count_q <= '0;
					recent_q      <= '0;
					idx_q         <= '0;
				end
				ST_SEND_OUT: begin
					if (out_free) idx_q <= idx_nxt;
				end
				ST_REPLY_CRC: begin
					if (crc_rsp.done) begin
						phase_q       <= PH_RECV;
						reply_crc_q   <= crc_rsp.crc;
						reply_count_q <= reply_cnt_inc;
						recent_q      <= {recent_q[7:0], byte_q};
						act_q         <= act_nxt;
						fin_status_q  <= 1'b0;
					end
				end
				ST_RETRY: begin
					attempt_q    <= attempt_inc;
					fin_status_q <= 1'b1;
				end
				ST_FINISH: begin
					if (out_free) begin
						phase_q     <= PH_IDLE;
						cmd_count_q <= '0;
						cmd_crc_q   <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			case (state_q)
				ST_SEND_OUT: begin
					kind_q     <= KIND_TX;
					out_byte_q <= st_rd_data;
					status_q   <= 1'b0;
					last_q_out <= send_last;
				end
				ST_REPLY_OUT: begin
					kind_q     <= KIND_REPLY;
					out_byte_q <= byte_q;
					status_q   <= 1'b0;
					last_q_out <= (act_q == ACT_NONE);
				end
				default: begin
					kind_q     <= KIND_DONE;
					out_byte_q <= 8'h00;
					status_q   <= fin_status_q;
					last_q_out <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign out_byte  = out_byte_q;
	assign status    = status_q;
	assign last      = last_q_out;

	cre_crc_serial u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (crc_req),
		.rsp    (crc_rsp)
	);

	cre_cmd_store u_store (
		.clk     (clk),
		.wr      (st_wr),
		.rd_addr (idx_q[ADDR_W-1:0]),
		.rd_data (st_rd_data)
	);

	// crc results arrive only while the sequencer waits for them
	a_crc_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		crc_rsp.done |-> (state_q == ST_CMD_CRC || state_q == ST_HI_CRC ||
		                  state_q == ST_LO_CRC || state_q == ST_REPLY_CRC))
		else $error("crc result outside a crc wait state");

	// the command never outgrows the store
	a_store_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_count_q <= CMD_CNT_W'(STORE_DEPTH))
		else $error("command count beyond store depth");

	// a done result always closes the item and only it carries status
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (kind_q == KIND_DONE || status_q) |->
			kind_q == KIND_DONE && last_q_out)
		else $error("done result without last or stray status");

	// a new item is never taken while an item still has results to load
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_DECODE)
		else $error("item accepted outside idle");

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// testbench for the crc-16 command engine with reply check and retries
`timescale 1ns / 1ps

module tb_top;
	import cre_pkg::*;

	localparam int QUIET_LIMIT  = 4000;
	localparam int SETTLE_WAIT  = 24;
	localparam int RANDOM_ITEMS = 130;
	localparam int PHASE_ITEMS  = 33;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic       status;
		logic       last;
	} engine_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            req_type = '0;
	logic [7:0]            data_byte = '0;
	logic                  cmd_last = 1'b0;
	logic                  add_crc = 1'b0;
	logic [6:0]            reply_len = '0;
	logic                  reply_variable = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [1:0]            kind;
	logic [7:0]            out_byte;
	logic                  status;
	logic                  last;

	// shared run state
	engine_result_t awaited_results[$];
	engine_result_t step_results[$];
	int mismatch_count  = 0;
	int effective_items = 0;
	int hold_request    = 0;
	int quiet_cycles    = 0;
	bit calm            = 1'b0;

	// engine state as predicted
	logic [7:0]  stored_cmd [STORE_DEPTH];
	int          stored_len = 0;
	logic [15:0] cmd_crc_acc = '0;
	logic [15:0] reply_crc_acc = '0;
	logic [15:0] last_two = '0;
	int          reply_seen = 0;
	int          tries = 0;
	int          ticks_waited = 0;
	phase_t      eng_phase = PH_IDLE;
	logic        want_variable = 1'b0;
	int          want_len = 0;
	int          limit_reg = 3;
	int          timeout_reg = 10;

	crc_command_retry_engine dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.data_byte      (data_byte),
		.cmd_last       (cmd_last),
		.add_crc        (add_crc),
		.reply_len      (reply_len),
		.reply_variable (reply_variable),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.out_byte       (out_byte),
		.status         (status),
		.last           (last)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// crc-16/xmodem, one byte msb first
	function automatic logic [15:0] crc16_next(logic [15:0] c, logic [7:0] b);
		logic [15:0] r;
		r = c ^ {b, 8'h00};
		for (int i = 0; i < 8; i++)
			r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
		return r;
	endfunction

	function automatic void push_result(logic [1:0] k, logic [7:0] v, logic st);
		engine_result_t r;
		r.kind = k;
		r.value = v;
		r.status = st;
		r.last = 1'b0;
		step_results.push_back(r);
	endfunction

	function automatic void close_txn(logic st);
		push_result(KIND_DONE, 8'h00, st);
		eng_phase = PH_IDLE;
		stored_len = 0;
		cmd_crc_acc = '0;
	endfunction

	function automatic void transmit_command();
		for (int i = 0; i < stored_len; i++)
			push_result(KIND_TX, stored_cmd[i], 1'b0);
		eng_phase = PH_WAIT;
		ticks_waited = 0;
		reply_crc_acc = cmd_crc_acc;
		reply_seen = 0;
		last_two = '0;
	endfunction

	// a failed attempt either resends or gives up
	function automatic void count_failure();
		if (tries < 15)
			tries++;
		if (tries >= limit_reg)
			close_txn(1'b1);
		else
			transmit_command();
	endfunction

	function automatic void open_txn(logic add, logic [6:0] len, logic vr);
		logic [15:0] c;
		int n;
		n = len;
		if (n == 0)
			n = 1;
		if (n > MAX_REPLY_BYTES)
			n = MAX_REPLY_BYTES;
		want_len = n;
		want_variable = vr;
		// append the crc, high byte first
		if (add) begin
			c = cmd_crc_acc;
			stored_cmd[stored_len] = c[15:8];
			stored_cmd[stored_len + 1] = c[7:0];
			stored_len += 2;
			cmd_crc_acc = crc16_next(crc16_next(c, c[15:8]), c[7:0]);
		end
		tries = 0;
		if (limit_reg == 0)
			close_txn(1'b1);
		else
			transmit_command();
	endfunction

	function automatic void take_reply_byte(logic [7:0] b);
		logic end_mark;
		end_mark = (reply_seen >= 2) && (last_two[15:8] == 8'h00);
		push_result(KIND_REPLY, b, 1'b0);
		eng_phase = PH_RECV;
		reply_crc_acc = crc16_next(reply_crc_acc, b);
		if (reply_seen < 127)
			reply_seen++;
		last_two = {last_two[7:0], b};
		// judge the reply once it is complete
		if (want_variable) begin
			if (end_mark) begin
				if (reply_crc_acc == 16'h0000)
					close_txn(1'b0);
				else
					count_failure();
			end else if (reply_seen >= MAX_REPLY_BYTES) begin
				count_failure();
			end
		end else if (want_len == 1) begin
			if (b == ACK_VALUE)
				close_txn(1'b0);
			else
				count_failure();
		end else if (reply_seen >= want_len) begin
			if (reply_crc_acc == 16'h0000)
				close_txn(1'b0);
			else
				count_failure();
		end
	endfunction

	// advance the predicted engine by one item; returns 0 if the item is ignored
	function automatic bit predict_item(req_t r, logic [7:0] b, logic lst, logic add,
			logic [6:0] len, logic vr);
		bit taken;
		taken = 1'b0;
		step_results.delete();
		case (r)
			REQ_CMD: begin
				if (eng_phase == PH_IDLE) begin
					taken = 1'b1;
					if (stored_len < MAX_CMD_BYTES) begin
						stored_cmd[stored_len] = b;
						stored_len++;
						cmd_crc_acc = crc16_next(cmd_crc_acc, b);
					end
					if (lst)
						open_txn(add, len, vr);
				end
			end
			REQ_LINE: begin
				if (eng_phase != PH_IDLE) begin
					taken = 1'b1;
					take_reply_byte(b);
				end
			end
			REQ_TICK: begin
				if (eng_phase == PH_WAIT) begin
					taken = 1'b1;
					if (ticks_waited < 16'hFFFF)
						ticks_waited++;
					if (ticks_waited >= timeout_reg)
						count_failure();
				end
			end
			default: ;
		endcase
		if (step_results.size() > 0)
			step_results[step_results.size() - 1].last = 1'b1;
		for (int i = 0; i < step_results.size(); i++)
			awaited_results.push_back(step_results[i]);
		return taken;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// offer one item and wait until the engine takes it
	task automatic send_item(input req_t r, input logic [7:0] b, input logic lst,
			input logic add, input logic [6:0] len, input logic vr);
		int gap;
		gap = calm ? 0 : idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= r;
		data_byte <= b;
		cmd_last <= lst;
		add_crc <= add;
		reply_len <= len;
		reply_variable <= vr;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (predict_item(r, b, lst, add, len, vr))
			effective_items++;
	endtask

	task automatic send_cmd(input logic [7:0] b, input logic lst, input logic add,
			input logic [6:0] len, input logic vr);
		send_item(REQ_CMD, b, lst, add, len, vr);
	endtask

	task automatic send_line(input logic [7:0] b);
		send_item(REQ_LINE, b, 1'($urandom), 1'($urandom), 7'($urandom), 1'($urandom));
	endtask

	task automatic send_tick();
		send_item(REQ_TICK, 8'($urandom), 1'($urandom), 1'($urandom), 7'($urandom),
			1'($urandom));
	endtask

	// stop offering and wait until every predicted result has come
	task automatic drain_results();
		in_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic set_limits(input int retries, input int ticks);
		cfg_write <= 1'b1;
		cfg_index <= CFG_RETRY_LIMIT;
		cfg_data <= 16'(retries);
		@(posedge clk);
		cfg_index <= CFG_TIMEOUT_TICKS;
		cfg_data <= 16'(ticks);
		@(posedge clk);
		cfg_write <= 1'b0;
		limit_reg = retries & 15;
		timeout_reg = ticks & 16'hFFFF;
	endtask

	// ignored items: a command byte while busy or a tick after the reply started
	task automatic maybe_noise();
		if ($urandom_range(0, 99) < 8) begin
			if ($urandom_range(0, 1))
				send_cmd(8'($urandom), 1'($urandom), 1'($urandom), 7'($urandom), 1'($urandom));
			else
				send_tick();
		end
	endtask

	// reply that matches the expected form, corrupted when bad
	task automatic send_reply(input bit good);
		logic [15:0] tail;
		int k;
		if (!want_variable && want_len == 1) begin
			send_line(good ? ACK_VALUE : 8'($urandom_range(0, 254)));
		end else begin
			if (!want_variable) begin
				for (int i = 0; i < want_len - 2; i++) begin
					if (i > 0)
						maybe_noise();
					send_line(8'($urandom));
				end
				if (want_len > 2)
					maybe_noise();
			end else begin
				k = $urandom_range(0, 10);
				for (int i = 0; i < k; i++) begin
					if (i > 0)
						maybe_noise();
					send_line(8'($urandom_range(1, 255)));
				end
				if (k > 0)
					maybe_noise();
				send_line(8'h00);
				maybe_noise();
			end
			tail = reply_crc_acc;
			if (!good)
				tail[7:0] ^= 8'($urandom_range(1, 255));
			send_line(tail[15:8]);
			maybe_noise();
			send_line(tail[7:0]);
		end
	endtask

	// one attempt: timeout, overrun, or a good or bad reply
	task automatic answer_attempt();
		int r;
		int a0;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			a0 = tries;
			do
				send_tick();
			while (eng_phase == PH_WAIT && tries == a0);
		end else if (want_variable && r >= 94) begin
			repeat (MAX_REPLY_BYTES) send_line(8'($urandom_range(1, 255)));
		end else begin
			if (r < 25 && timeout_reg > 1)
				repeat ($urandom_range(1, timeout_reg - 1)) send_tick();
			send_reply(r < 70);
		end
	endtask

	task automatic random_transaction();
		int n;
		int r;
		logic add;
		logic vr;
		logic [6:0] len;
		// stray items while idle
		if ($urandom_range(0, 9) == 0) begin
			if ($urandom_range(0, 1))
				send_line(8'($urandom));
			else
				send_tick();
		end
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 36) : $urandom_range(1, 6);
		add = ($urandom_range(0, 6) != 0);
		r = $urandom_range(0, 99);
		vr = 1'b0;
		if (r < 35)
			len = 7'd1;
		else if (r < 40)
			len = 7'd0;
		else if (r < 43)
			len = 7'($urandom_range(65, 127));
		else if (r < 78)
			len = 7'($urandom_range(2, 8));
		else begin
			vr = 1'b1;
			len = 7'($urandom);
		end
		for (int i = 0; i < n - 1; i++)
			send_cmd(8'($urandom), 1'b0, 1'($urandom), 7'($urandom), 1'($urandom));
		send_cmd(8'($urandom), 1'b1, add, len, vr);
		while (eng_phase != PH_IDLE)
			answer_attempt();
	endtask

	// acknowledge-only reply, stray items, a bad acknowledge
	task automatic test_ack_reply();
		send_line(8'h3C);
		send_tick();
		send_cmd(8'h00, 1'b0, 1'b0, 7'd5, 1'b1);
		send_cmd(8'hFF, 1'b1, 1'b0, 7'd0, 1'b0);
		send_cmd(8'h55, 1'b1, 1'b1, 7'd3, 1'b0);
		send_line(8'h00);
		send_tick();
		send_line(ACK_VALUE);
		drain_results();
	endtask

	// fixed length reply closed by its crc
	task automatic test_fixed_crc_reply();
		logic [15:0] tail;
		send_cmd(8'hA5, 1'b0, 1'b0, 7'd0, 1'b0);
		send_cmd(8'h5A, 1'b1, 1'b1, 7'd4, 1'b0);
		send_line(8'h80);
		send_line(8'h01);
		tail = reply_crc_acc;
		send_line(tail[15:8]);
		send_line(tail[7:0]);
		drain_results();
	endtask

	// variable reply: a bad crc, then a good one
	task automatic test_variable_reply();
		logic [15:0] tail;
		send_cmd(8'h0F, 1'b1, 1'b1, 7'd127, 1'b1);
		send_line(8'h7E);
		send_line(8'h00);
		tail = reply_crc_acc ^ 16'h0001;
		send_line(tail[15:8]);
		send_line(tail[7:0]);
		send_line(8'h00);
		tail = reply_crc_acc;
		send_line(tail[15:8]);
		send_line(tail[7:0]);
		drain_results();
	endtask

	// zero timeout, zero retry limit, largest timeout
	task automatic test_timeouts_and_limits();
		logic [15:0] tail;
		set_limits(2, 0);
		send_cmd(8'h33, 1'b1, 1'b0, 7'd1, 1'b0);
		send_tick();
		send_tick();
		drain_results();
		set_limits(0, 0);
		send_cmd(8'hC3, 1'b1, 1'b1, 7'd1, 1'b0);
		drain_results();
		set_limits(15, 65535);
		send_cmd(8'h99, 1'b1, 1'b1, 7'd2, 1'b0);
		repeat (3) send_tick();
		tail = reply_crc_acc;
		send_line(tail[15:8]);
		send_line(tail[7:0]);
		drain_results();
	endtask

	// overlong command while the receiver holds off, so the engine backs up
	task automatic test_backpressure_overflow();
		calm = 1'b1;
		hold_request = 400;
		for (int i = 0; i < MAX_CMD_BYTES + 1; i++)
			send_cmd(8'($urandom), 1'b0, 1'($urandom), 7'($urandom), 1'($urandom));
		send_cmd(8'($urandom), 1'b1, 1'b1, 7'd1, 1'b0);
		send_line(ACK_VALUE);
		drain_results();
		calm = 1'b0;
	endtask

	task automatic test_random_traffic();
		int start_items;
		int target;
		int phase_no;
		start_items = effective_items;
		phase_no = 0;
		while (effective_items - start_items < RANDOM_ITEMS) begin
			case (phase_no % 4)
				0: set_limits(1, 1);
				1: set_limits(15, 3);
				2: begin
					set_limits($urandom_range(2, 14), 5);
					calm = 1'b1;
				end
				default: set_limits(4, 2);
			endcase
			target = effective_items + PHASE_ITEMS;
			while (effective_items < target)
				random_transaction();
			drain_results();
			calm = 1'b0;
			phase_no++;
		end
	endtask

	// receiver stalls, with one long hold-off on request
	initial begin : receiver_stalls
		int g;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				g = hold_request;
				hold_request = 0;
				out_stall <= 1'b1;
				repeat (g) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				g = (calm || $urandom_range(0, 2) != 0) ? 0 : idle_gap();
				if (g > 0) begin
					out_stall <= 1'b1;
					repeat (g) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	// compare each accepted result with the oldest prediction
	always @(posedge clk) begin : result_check
		engine_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending: kind %0d byte %02h",
					kind, out_byte));
			end else begin
				want = awaited_results.pop_front();
				if (kind !== want.kind)
					report_mismatch($sformatf("kind %0d, predicted %0d", kind, want.kind));
				if (out_byte !== want.value)
					report_mismatch($sformatf("byte %02h, predicted %02h", out_byte, want.value));
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, predicted %0d", status, want.status));
				if (last !== want.last)
					report_mismatch($sformatf("last %0d, predicted %0d", last, want.last));
			end
		end
	end

	// watchdog on cycles without any accepted item or result
	initial begin : watchdog
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("crc_command_retry_engine verification failed");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_ack_reply();
		test_fixed_crc_reply();
		test_variable_reply();
		test_timeouts_and_limits();
		test_backpressure_overflow();
		test_random_traffic();
		drain_results();
		if (mismatch_count == 0)
			$display("crc_command_retry_engine verification clean");
		else
			$display("crc_command_retry_engine verification failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/cre_pkg.sv
rtl/cre_crc_serial.sv
rtl/cre_cmd_store.sv
rtl/crc_command_retry_engine.sv
tb/tb_top.sv
